FILE: hdl/naidr_pkg.sv
// naidr_pkg: shared types, codes and text tables of the identify / log page responder.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package naidr_pkg;

    localparam int unsigned PAGE_BYTES    = 4096;
    localparam int unsigned COMMAND_BYTES = 64;
    localparam int unsigned CMD_WORDS     = COMMAND_BYTES / 4;
    localparam int unsigned CMD_IDX_W     = $clog2(CMD_WORDS);

    localparam int unsigned INDEX_W   = 10;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned LEN_W     = 13;
    localparam int unsigned CAP_W     = 40;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned OFF_W     = INDEX_W + 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRIMARY_CAP  = 3'd0,
        REG_LINK_CAP     = 3'd1,
        REG_MAX_XFER_EXP = 3'd2,
        REG_PAIRED       = 3'd3,
        REG_PRIMARY_RO   = 3'd4,
        REG_VWC          = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_ID_NS   = 3'd1,
        KIND_ID_CTRL = 3'd2,
        KIND_ID_LIST = 3'd3,
        KIND_LOG1    = 3'd4,
        KIND_LOG2    = 3'd5,
        KIND_LOG3    = 3'd6
    } payload_kind_t;

    typedef enum logic [1:0] {
        OUTCOME_BAD_CFG   = 2'd0,
        OUTCOME_UNHANDLED = 2'd1,
        OUTCOME_HANDLED   = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FIELD = 2'd1,
        ST_NS    = 2'd2
    } status_t;

    localparam logic       ACT_WRITE = 1'b0;
    localparam logic       ACT_READ  = 1'b1;

    localparam logic [7:0] OPC_GET_LOG  = 8'h02;
    localparam logic [7:0] OPC_IDENTIFY = 8'h06;
    localparam logic [7:0] CNS_NS       = 8'd0;
    localparam logic [7:0] CNS_CTRL     = 8'd1;
    localparam logic [7:0] CNS_LIST     = 8'd2;
    localparam logic [7:0] LID_FIRST    = 8'd1;
    localparam logic [7:0] LID_LAST     = 8'd3;
    localparam logic [7:0] MDTS_MAX     = 8'd8;
    localparam logic [31:0] NSID_ALL    = 32'hFFFF_FFFF;
    localparam logic [31:0] NUMD_MAX    = 32'(PAGE_BYTES / 4 - 1);

    localparam logic [15:0] VENDOR_ID   = 16'h1234;
    localparam logic [31:0] VERSION     = 32'h0001_0300;
    localparam logic [7:0]  SQES        = 8'h66;
    localparam logic [7:0]  CQES        = 8'h44;
    localparam logic [15:0] LOG2_TEMP   = 16'd300;
    localparam logic [7:0]  LOG2_SPARE  = 8'd100;
    localparam logic [7:0]  NS_LBADS    = 8'd12;
    localparam logic [7:0]  SPACE       = 8'h20;

    localparam int unsigned SERIAL_LEN = 20;
    localparam int unsigned MODEL_LEN  = 31;
    localparam int unsigned FW_LEN     = 3;
    localparam logic [8*SERIAL_LEN-1:0] SERIAL_TXT = "ADMIN-RO-00000000001";
    localparam logic [8*MODEL_LEN-1:0]  MODEL_TXT  = "ADMIN IDENTIFY READ ONLY BRIDGE";
    localparam logic [8*FW_LEN-1:0]     FW_TXT     = "S92";
    localparam logic [8*FW_LEN-1:0]     LOG3_TXT   = "S93";

    function automatic logic [7:0] serial_char(input logic [5:0] i);
        logic [7:0] c;
        c = SPACE;
        if (32'(i) < SERIAL_LEN)
            c = SERIAL_TXT[8*(SERIAL_LEN-1-32'(i)) +: 8];
        return c;
    endfunction

    function automatic logic [7:0] model_char(input logic [5:0] i);
        logic [7:0] c;
        c = SPACE;
        if (32'(i) < MODEL_LEN)
            c = MODEL_TXT[8*(MODEL_LEN-1-32'(i)) +: 8];
        return c;
    endfunction

    function automatic logic [7:0] short_char(input logic [8*FW_LEN-1:0] txt,
                                              input logic [2:0] i);
        logic [7:0] c;
        c = SPACE;
        if (32'(i) < FW_LEN)
            c = txt[8*(FW_LEN-1-32'(i)) +: 8];
        return c;
    endfunction

    function automatic logic [7:0] ctrl_byte(input logic [OFF_W-1:0] off,
                                             input logic [7:0] mdts,
                                             input logic paired,
                                             input logic vwc);
        logic [7:0] b;
        logic [OFF_W-1:0] rel;
        b   = 8'h00;
        rel = '0;
        if (off < OFF_W'(4))
            b = off[0] ? VENDOR_ID[15:8] : VENDOR_ID[7:0];
        else if (off < OFF_W'(24))
        begin
            rel = off - OFF_W'(4);
            b   = serial_char(rel[5:0]);
        end
        else if (off < OFF_W'(64))
        begin
            rel = off - OFF_W'(24);
            b   = model_char(rel[5:0]);
        end
        else if (off < OFF_W'(72))
        begin
            rel = off - OFF_W'(64);
            b   = short_char(FW_TXT, rel[2:0]);
        end
        else if (off == OFF_W'(77))
            b = mdts;
        else if (off == OFF_W'(78))
            b = 8'd1;
        else if (off >= OFF_W'(80) && off < OFF_W'(84))
            b = VERSION[8*off[1:0] +: 8];
        else if (off == OFF_W'(512))
            b = SQES;
        else if (off == OFF_W'(513))
            b = CQES;
        else if (off == OFF_W'(516))
            b = paired ? 8'd2 : 8'd1;
        else if (off == OFF_W'(525))
            b = {7'd0, vwc};
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/naidr_if.sv
// naidr_cmd_if / naidr_rsp_if: valid/ready channels of the responder.
// Depends on naidr_pkg for field widths.
`default_nettype none

interface naidr_cmd_if
    import naidr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               action;
    logic [INDEX_W-1:0] word_index;
    logic [DATA_W-1:0]  word_data;

    modport source (output valid, output action, output word_index, output word_data,
                    input ready);
    modport sink   (input valid, input action, input word_index, input word_data,
                    output ready);
endinterface

interface naidr_rsp_if
    import naidr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              evaluated;
    logic [1:0]        outcome;
    logic [1:0]        completion_status;
    logic [LEN_W-1:0]  payload_bytes;

    modport source (output valid, output read_data, output evaluated, output outcome,
                    output completion_status, output payload_bytes, input ready);
    modport sink   (input valid, input read_data, input evaluated, input outcome,
                    input completion_status, input payload_bytes, output ready);
endinterface

`default_nettype wire

FILE: hdl/nvme_admin_identify_log_responder_top.sv
// nvme_admin_identify_log_responder_top: NVMe admin Identify / Get Log Page responder.
// Depends on naidr_pkg and the channel interfaces in naidr_if.sv.
//
// Usage:
//   cmd carries one beat per bus access: action 0 writes command dword word_index
//   (0..15, others ignored), action 1 reads payload dword word_index.
//   Writing dword 15 evaluates the 64-byte command against the configuration.
//   rsp returns exactly one beat per cmd beat, in order: read_data for reads,
//   evaluated/outcome/completion_status/payload_bytes for the final command write.
//   cfg_we/cfg_index/cfg_data write a configuration register;
//   write only while no beat is in flight. Indexes beyond 5 are ignored.
// Timing:
//   one input register, one result register: an accepted beat passes through the
//   input register and then the result register before it is presented on rsp.
//   When rsp stalls, the result register holds and the input register still
//   takes one more beat; cmd.ready drops once both are full.
// Reset:
//   rst_n clears the command words, the latched payload (no payload) and the
//   pipeline; configuration returns to primary capacity 1, all else zero.
`default_nettype none

module nvme_admin_identify_log_responder_top
    import naidr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    naidr_cmd_if.sink                 cmd,
    naidr_rsp_if.source               rsp,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CAP_W-1:0]     cfg_data
);

    // configuration
    logic [CAP_W-1:0] primary_cap_reg;
    logic [CAP_W-1:0] link_cap_reg;
    logic [7:0]       mdts_reg;
    logic             paired_reg;
    logic             primary_ro_reg;
    logic             vwc_reg;

    // command and latched payload state
    logic [DATA_W-1:0] cmd_words_reg [CMD_WORDS];
    payload_kind_t     kind_reg, kind_next;
    logic [DATA_W-1:0] nsid_reg;
    logic [LEN_W-1:0]  length_reg, length_next;

    // input register
    logic               s1_valid_reg;
    logic               s1_action_reg;
    logic [INDEX_W-1:0] s1_index_reg;
    logic [DATA_W-1:0]  s1_data_reg;

    // result register
    logic              out_valid_reg;
    logic [DATA_W-1:0] read_data_reg, read_data_next;
    logic              evaluated_reg, evaluated_next;
    outcome_t          outcome_reg, outcome_next;
    status_t           status_reg, status_next;
    logic [LEN_W-1:0]  bytes_reg, bytes_next;

    logic adv_out, adv_in, s1_fire, cmd_fire;
    logic is_write, is_last;

    assign adv_out   = !out_valid_reg || rsp.ready;
    assign adv_in    = !s1_valid_reg || adv_out;
    assign cmd.ready = adv_in;
    assign cmd_fire  = cmd.valid && adv_in;
    assign s1_fire   = s1_valid_reg && adv_out;

    assign is_write = (s1_action_reg == ACT_WRITE) && (s1_index_reg < INDEX_W'(CMD_WORDS));
    assign is_last  = is_write && (s1_index_reg == INDEX_W'(CMD_WORDS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primary_cap_reg <= CAP_W'(1);
            link_cap_reg    <= '0;
            mdts_reg        <= '0;
            paired_reg      <= 1'b0;
            primary_ro_reg  <= 1'b0;
            vwc_reg         <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PRIMARY_CAP:  primary_cap_reg <= cfg_data;
                REG_LINK_CAP:     link_cap_reg    <= cfg_data;
                REG_MAX_XFER_EXP: mdts_reg        <= cfg_data[7:0];
                REG_PAIRED:       paired_reg      <= cfg_data[0];
                REG_PRIMARY_RO:   primary_ro_reg  <= cfg_data[0];
                REG_VWC:          vwc_reg         <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // ---------------- command evaluation ----------------
    logic [DATA_W-1:0] w15;
    logic [7:0]        opcode, sel;
    logic [31:0]       numd;
    logic              cfg_ok;
    outcome_t          ev_outcome;
    status_t           ev_status;
    payload_kind_t     ev_kind;
    logic [LEN_W-1:0]  ev_len;

    assign w15    = s1_data_reg;
    assign opcode = cmd_words_reg[0][7:0];
    assign sel    = cmd_words_reg[10][7:0];
    assign numd   = {cmd_words_reg[11][15:0], cmd_words_reg[10][31:16]};
    assign cfg_ok = (primary_cap_reg != '0) && (mdts_reg <= MDTS_MAX)
                    && !(paired_reg && (link_cap_reg == '0));

    always_comb
    begin
        ev_outcome = OUTCOME_HANDLED;
        ev_status  = ST_FIELD;
        ev_kind    = KIND_NONE;
        ev_len     = '0;
        if (!cfg_ok)
            ev_outcome = OUTCOME_BAD_CFG;
        else if (opcode != OPC_IDENTIFY && opcode != OPC_GET_LOG)
            ev_outcome = OUTCOME_UNHANDLED;
        else if (cmd_words_reg[0][15:8] != 8'd0 || cmd_words_reg[4] != '0
                 || cmd_words_reg[5] != '0)
            ev_status = ST_FIELD;
        else if (opcode == OPC_IDENTIFY)
        begin
            if (cmd_words_reg[10][31:8] == '0 && cmd_words_reg[11] == '0
                && cmd_words_reg[12] == '0 && cmd_words_reg[13] == '0
                && cmd_words_reg[14] == '0 && w15 == '0)
            begin
                if (sel == CNS_NS)
                begin
                    if (cmd_words_reg[1] == 32'd1 || (paired_reg && cmd_words_reg[1] == 32'd2))
                        ev_kind = KIND_ID_NS;
                    else
                        ev_status = ST_NS;
                end
                else if (sel == CNS_CTRL)
                begin
                    if (cmd_words_reg[1] == '0 || cmd_words_reg[1] == NSID_ALL)
                        ev_kind = KIND_ID_CTRL;
                    else
                        ev_status = ST_NS;
                end
                else if (sel == CNS_LIST)
                    ev_kind = KIND_ID_LIST;
                if (ev_kind != KIND_NONE)
                begin
                    ev_status = ST_OK;
                    ev_len    = LEN_W'(PAGE_BYTES);
                end
            end
        end
        else
        begin
            if (sel >= LID_FIRST && sel <= LID_LAST && numd <= NUMD_MAX
                && cmd_words_reg[12] == '0 && cmd_words_reg[13] == '0)
            begin
                ev_status = ST_OK;
                ev_kind   = payload_kind_t'(3'(KIND_LOG1) + sel[2:0] - 3'd1);
                ev_len    = {numd[LEN_W-3:0] + (LEN_W-2)'(1), 2'b00};
            end
        end
    end

    // ---------------- payload read ----------------
    logic [OFF_W-1:0] base;
    logic [DATA_W-1:0] rd_word;
    logic [DATA_W-1:0] ns_blocks;
    logic [63:0]       blocks;
    logic [DATA_W-1:0] list0, list1;

    assign base   = {s1_index_reg, 2'b00};
    assign blocks = 64'((nsid_reg == 32'd1) ? primary_cap_reg : link_cap_reg);
    assign ns_blocks = '0;

    always_comb
    begin
        logic [OFF_W-1:0] off;
        logic [7:0]       b;
        list0 = '0;
        list1 = '0;
        if (nsid_reg == '0)
        begin
            list0 = 32'd1;
            if (paired_reg)
                list1 = 32'd2;
        end
        else if (paired_reg && nsid_reg == 32'd1)
            list0 = 32'd2;

        rd_word = ns_blocks;
        for (int i = 0; i < 4; i++)
        begin
            off = {s1_index_reg, 2'(i)};
            b   = 8'h00;
            case (kind_reg)
                KIND_ID_NS:
                begin
                    if (off < OFF_W'(24))
                        b = blocks[8*off[2:0] +: 8];
                    else if (off == OFF_W'(99))
                        b = {7'd0, (nsid_reg == 32'd1) && primary_ro_reg};
                    else if (off == OFF_W'(130))
                        b = NS_LBADS;
                end
                KIND_ID_CTRL:
                    b = ctrl_byte(off, mdts_reg, paired_reg, vwc_reg);
                KIND_LOG2:
                begin
                    if (off == OFF_W'(1))
                        b = LOG2_TEMP[7:0];
                    else if (off == OFF_W'(2))
                        b = LOG2_TEMP[15:8];
                    else if (off == OFF_W'(3))
                        b = LOG2_SPARE;
                end
                KIND_LOG3:
                begin
                    if (length_reg >= LEN_W'(16))
                    begin
                        if (off == '0)
                            b = 8'd1;
                        else if (off >= OFF_W'(8) && off < OFF_W'(16))
                            b = short_char(LOG3_TXT, off[2:0]);
                    end
                end
                default: b = 8'h00;
            endcase
            rd_word[8*i +: 8] = b;
        end

        if (kind_reg == KIND_NONE || {1'b0, base} >= length_reg)
            rd_word = '0;
        else if (kind_reg == KIND_ID_LIST)
        begin
            if (s1_index_reg == INDEX_W'(0))
                rd_word = list0;
            else if (s1_index_reg == INDEX_W'(1))
                rd_word = list1;
            else
                rd_word = '0;
        end
    end

    // ---------------- result and state next ----------------
    always_comb
    begin
        read_data_next = '0;
        evaluated_next = 1'b0;
        outcome_next   = OUTCOME_BAD_CFG;
        status_next    = ST_OK;
        bytes_next     = '0;
        kind_next      = kind_reg;
        length_next    = length_reg;
        if (s1_action_reg == ACT_READ)
            read_data_next = rd_word;
        else if (is_last)
        begin
            evaluated_next = 1'b1;
            outcome_next   = ev_outcome;
            status_next    = ev_status;
            bytes_next     = ev_len;
            kind_next      = ev_kind;
            length_next    = ev_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CMD_WORDS; i++)
                cmd_words_reg[i] <= '0;
            kind_reg   <= KIND_NONE;
            nsid_reg   <= '0;
            length_reg <= '0;
        end
        else if (s1_fire && is_write)
        begin
            cmd_words_reg[s1_index_reg[CMD_IDX_W-1:0]] <= s1_data_reg;
            if (is_last)
            begin
                kind_reg   <= kind_next;
                nsid_reg   <= cmd_words_reg[1];
                length_reg <= length_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_in)
                s1_valid_reg <= cmd.valid;
            if (adv_out)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_action_reg <= cmd.action;
            s1_index_reg  <= cmd.word_index;
            s1_data_reg   <= cmd.word_data;
        end
        if (s1_fire)
        begin
            read_data_reg <= read_data_next;
            evaluated_reg <= evaluated_next;
            outcome_reg   <= outcome_next;
            status_reg    <= status_next;
            bytes_reg     <= bytes_next;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.read_data         = read_data_reg;
    assign rsp.evaluated         = evaluated_reg;
    assign rsp.outcome           = evaluated_reg ? outcome_reg : OUTCOME_BAD_CFG;
    assign rsp.completion_status = evaluated_reg ? status_reg : ST_OK;
    assign rsp.payload_bytes     = bytes_reg;

endmodule

`default_nettype wire
